@@ rtl/core/tmw_pkg.sv @@
`default_nettype none
package tmw_pkg;

   localparam int VISIBLE_COLS = 48;
   localparam int VISIBLE_ROWS = 28;
   localparam int TAB_STOP     = 4;
   localparam int PACKED_LIMIT = 32;
   localparam int PAL_SHIFT    = 14;
   localparam int SEG_SHIFT    = 12;
   localparam int ROW_SHIFT    = 6;
   localparam int MAX_GLYPH    = 8;

   localparam logic [7:0] CODE_TAB = 8'd9;
   localparam logic [7:0] CODE_NL  = 8'd10;
   localparam logic [7:0] CODE_CR  = 8'd13;

   localparam logic [2:0] REG_FONT_CHAR_BASE  = 3'd0;
   localparam logic [2:0] REG_GLYPH_WIDTH     = 3'd1;
   localparam logic [2:0] REG_GLYPH_HEIGHT    = 3'd2;
   localparam logic [2:0] REG_FONT_CHAR_COUNT = 3'd3;
   localparam logic [2:0] REG_FONT_FIRST_CODE = 3'd4;
   localparam logic [2:0] REG_PALETTE         = 3'd5;
   localparam logic [2:0] REG_MAP_SEGMENT     = 3'd6;

   typedef struct packed {
      logic [10:0] font_char_base;
      logic [3:0]  glyph_width;
      logic [3:0]  glyph_height;
      logic [8:0]  font_char_count;
      logic [7:0]  font_first_code;
      logic [1:0]  palette;
      logic [3:0]  map_segment;
   } cfg_type;

   typedef struct packed {
      logic load;
      logic mul;
      logic base;
      logic step;
      logic advance;
   } ctrl_cmd_type;

   typedef struct packed {
      logic draw;
      logic zero_size;
      logic out_free;
      logic last_pos;
   } ctrl_sts_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_MUL,
      ST_BASE,
      ST_EMIT
   } state_type;

endpackage
`default_nettype wire

@@ rtl/core/tmw_csr.sv @@
`default_nettype none
module tmw_csr (
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire logic           csr_valid,
   output logic                csr_ready,
   input  wire logic [2:0]     csr_index,
   input  wire logic [10:0]    csr_wdata,
   output tmw_pkg::cfg_type    cfg
);

   logic [10:0] font_char_base_ff;
   logic [3:0]  glyph_width_ff;
   logic [3:0]  glyph_height_ff;
   logic [8:0]  font_char_count_ff;
   logic [7:0]  font_first_code_ff;
   logic [1:0]  palette_ff;
   logic [3:0]  map_segment_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         font_char_base_ff  <= 11'd0;
         glyph_width_ff     <= 4'd1;
         glyph_height_ff    <= 4'd1;
         font_char_count_ff <= 9'd256;
         font_first_code_ff <= 8'd0;
         palette_ff         <= 2'd0;
         map_segment_ff     <= 4'd0;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            tmw_pkg::REG_FONT_CHAR_BASE:  font_char_base_ff  <= csr_wdata;
            tmw_pkg::REG_GLYPH_WIDTH:     glyph_width_ff     <= csr_wdata[3:0];
            tmw_pkg::REG_GLYPH_HEIGHT:    glyph_height_ff    <= csr_wdata[3:0];
            tmw_pkg::REG_FONT_CHAR_COUNT: font_char_count_ff <= csr_wdata[8:0];
            tmw_pkg::REG_FONT_FIRST_CODE: font_first_code_ff <= csr_wdata[7:0];
            tmw_pkg::REG_PALETTE:         palette_ff         <= csr_wdata[1:0];
            tmw_pkg::REG_MAP_SEGMENT:     map_segment_ff     <= csr_wdata[3:0];
            default: begin
            end
         endcase
      end
   end

   // glyph sizes above eight act as eight
   always_comb begin
      cfg.font_char_base  = font_char_base_ff;
      cfg.glyph_width     = (glyph_width_ff > 4'(tmw_pkg::MAX_GLYPH))
                            ? 4'(tmw_pkg::MAX_GLYPH) : glyph_width_ff;
      cfg.glyph_height    = (glyph_height_ff > 4'(tmw_pkg::MAX_GLYPH))
                            ? 4'(tmw_pkg::MAX_GLYPH) : glyph_height_ff;
      cfg.font_char_count = font_char_count_ff;
      cfg.font_first_code = font_first_code_ff;
      cfg.palette         = palette_ff;
      cfg.map_segment     = map_segment_ff;
   end

endmodule
`default_nettype wire

@@ rtl/core/tmw_ctrl.sv @@
`default_nettype none
module tmw_ctrl (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 in_valid,
   output logic                      in_ready,
   input  wire tmw_pkg::ctrl_sts_type sts,
   output tmw_pkg::ctrl_cmd_type     cmd
);

   tmw_pkg::state_type state_ff;
   tmw_pkg::state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= tmw_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         tmw_pkg::ST_IDLE: begin
            if (in_valid && sts.draw) begin
               state_in = tmw_pkg::ST_MUL;
            end
         end
         tmw_pkg::ST_MUL: begin
            state_in = tmw_pkg::ST_BASE;
         end
         tmw_pkg::ST_BASE: begin
            state_in = sts.zero_size ? tmw_pkg::ST_IDLE : tmw_pkg::ST_EMIT;
         end
         tmw_pkg::ST_EMIT: begin
            if (sts.out_free && sts.last_pos) begin
               state_in = tmw_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = tmw_pkg::ST_IDLE;
         end
      endcase
   end

   always_comb begin
      in_ready    = 1'b0;
      cmd         = '0;
      case (state_ff)
         tmw_pkg::ST_IDLE: begin
            in_ready = 1'b1;
            cmd.load = in_valid;
         end
         tmw_pkg::ST_MUL: begin
            cmd.mul = 1'b1;
         end
         tmw_pkg::ST_BASE: begin
            cmd.base    = 1'b1;
            cmd.advance = sts.zero_size;
         end
         tmw_pkg::ST_EMIT: begin
            cmd.step    = sts.out_free;
            cmd.advance = sts.out_free && sts.last_pos;
         end
         default: begin
         end
      endcase
   end

endmodule
`default_nettype wire

@@ rtl/core/tmw_dpath.sv @@
`default_nettype none
module tmw_dpath (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire tmw_pkg::cfg_type      cfg,
   input  wire tmw_pkg::ctrl_cmd_type cmd,
   output tmw_pkg::ctrl_sts_type      sts,
   input  wire logic                  in_first,
   input  wire logic [7:0]            in_start_x,
   input  wire logic [7:0]            in_start_y,
   input  wire logic [7:0]            in_char_code,
   output logic                       out_valid,
   input  wire logic                  out_ready,
   output logic [15:0]                out_map_address,
   output logic [15:0]                out_tile_word,
   output logic                       out_last
);

   logic [7:0]  col_ff, row_ff, ls_ff;
   logic [7:0]  col_in, row_in, ls_in;
   logic [7:0]  g_ff;
   logic [10:0] t_ff;
   logic [8:0]  stride_ff;
   logic [15:0] pos_ff;
   logic [15:0] base_ff;
   logic [2:0]  ox_ff, oy_ff;
   logic [10:0] oy_off_ff;
   logic        out_valid_ff;
   logic [15:0] out_addr_ff, out_tile_ff;
   logic        out_last_ff;

   logic [7:0]  eff_col, eff_row, eff_ls;
   logic        drop, is_tab, is_nl;
   logic [11:0] tab_prod;
   logic [7:0]  adv_col;
   logic [2:0]  gh_m1;
   logic [8:0]  hi_prod;
   logic        ox_last, oy_last;
   logic [15:0] tile_sum;
   logic [15:0] addr_sum;

   always_comb begin
      eff_col = in_first ? in_start_x : col_ff;
      eff_row = in_first ? in_start_y : row_ff;
      eff_ls  = in_first ? in_start_x : ls_ff;
      drop    = (eff_col >= 8'(tmw_pkg::VISIBLE_COLS)) ||
                (eff_row >= 8'(tmw_pkg::VISIBLE_ROWS)) ||
                (in_char_code == tmw_pkg::CODE_CR);
      is_tab  = in_char_code == tmw_pkg::CODE_TAB;
      is_nl   = in_char_code == tmw_pkg::CODE_NL;
      tab_prod = (12'(eff_col / 8'(tmw_pkg::TAB_STOP)) + 12'd1) *
                 12'(tmw_pkg::TAB_STOP) * 12'(cfg.glyph_width);
      adv_col = col_ff + 8'(cfg.glyph_width);
   end

   // cursor update
   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      ls_in  = ls_ff;
      if (cmd.load) begin
         col_in = eff_col;
         row_in = eff_row;
         ls_in  = eff_ls;
         if (!drop && is_tab) begin
            col_in = tab_prod[7:0];
         end else if (!drop && is_nl) begin
            row_in = eff_row + 8'(cfg.glyph_height);
            col_in = eff_ls;
         end
      end else if (cmd.advance) begin
         if (adv_col >= 8'(tmw_pkg::VISIBLE_COLS)) begin
            row_in = row_ff + 8'(cfg.glyph_height);
            col_in = ls_ff;
         end else begin
            col_in = adv_col;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= 8'd0;
         row_ff <= 8'd0;
         ls_ff  <= 8'd0;
      end else begin
         col_ff <= col_in;
         row_ff <= row_in;
         ls_ff  <= ls_in;
      end
   end

   always_comb begin
      gh_m1   = (cfg.glyph_height == 4'd0) ? 3'd0 : 3'(cfg.glyph_height - 4'd1);
      hi_prod = 9'(t_ff[10:5]) * 9'(gh_m1);
      ox_last = {1'b0, ox_ff} == (cfg.glyph_width - 4'd1);
      oy_last = {1'b0, oy_ff} == (cfg.glyph_height - 4'd1);
      tile_sum = base_ff + 16'(ox_ff) + 16'(oy_off_ff);
      addr_sum = pos_ff + 16'(ox_ff) + 16'({oy_ff, 6'd0});
   end

   // glyph setup and position counters
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         g_ff <= in_char_code - cfg.font_first_code;
      end
      if (cmd.mul) begin
         t_ff      <= 11'(g_ff) * 11'(cfg.glyph_width);
         stride_ff <= (cfg.font_char_count < 9'(tmw_pkg::PACKED_LIMIT))
                      ? 9'(cfg.font_char_count[4:0]) * 9'(cfg.glyph_width)
                      : 9'(tmw_pkg::PACKED_LIMIT);
         pos_ff    <= {cfg.map_segment, 12'd0} + 16'({row_ff, 6'd0}) + 16'(col_ff);
      end
      if (cmd.base) begin
         base_ff   <= 16'(cfg.font_char_base) + 16'(t_ff) + 16'({hi_prod, 5'd0});
         ox_ff     <= 3'd0;
         oy_ff     <= 3'd0;
         oy_off_ff <= 11'd0;
      end else if (cmd.step) begin
         if (oy_last) begin
            oy_ff     <= 3'd0;
            oy_off_ff <= 11'd0;
            ox_ff     <= ox_ff + 3'd1;
         end else begin
            oy_ff     <= oy_ff + 3'd1;
            oy_off_ff <= oy_off_ff + 11'(stride_ff);
         end
      end
   end

   // output word register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (cmd.step) begin
         out_valid_ff <= 1'b1;
      end else if (out_ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.step) begin
         out_addr_ff <= addr_sum;
         out_tile_ff <= tile_sum | {cfg.palette, 14'd0};
         out_last_ff <= ox_last && oy_last;
      end
   end

   always_comb begin
      sts.draw      = !drop && !is_tab && !is_nl;
      sts.zero_size = (cfg.glyph_width == 4'd0) || (cfg.glyph_height == 4'd0);
      sts.out_free  = !out_valid_ff || out_ready;
      sts.last_pos  = ox_last && oy_last;
   end

   assign out_valid       = out_valid_ff;
   assign out_map_address = out_addr_ff;
   assign out_tile_word   = out_tile_ff;
   assign out_last        = out_last_ff;

endmodule
`default_nettype wire

@@ rtl/core/text_to_tile_map_writer_top.sv @@
// a drawn character's first word passes MUL, BASE, EMIT and the output register;
// it holds the input until its last word is loaded, one word per cycle from the
// emit counters while the output is free; tab, new line, dropped: input not held
// the last word may still wait at the output while the next character is accepted
// reset: synchronous, clears the cursor to 0 and sets registers to their defaults
`default_nettype none
module text_to_tile_map_writer_top (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [23:0] req_tdata,   // start_x, start_y, char_code
   input  wire logic        req_tuser,   // first
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [31:0]      rsp_tdata,   // map_address, tile_word
   output logic             rsp_tlast,   // last
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [2:0]  csr_index,
   input  wire logic [10:0] csr_wdata
);

   tmw_pkg::cfg_type      cfg;
   tmw_pkg::ctrl_cmd_type cmd;
   tmw_pkg::ctrl_sts_type sts;
   logic [15:0]           map_address;
   logic [15:0]           tile_word;

   tmw_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   tmw_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .in_valid (req_tvalid),
      .in_ready (req_tready),
      .sts      (sts),
      .cmd      (cmd)
   );

   tmw_dpath u_dpath (
      .clock           (clock),
      .reset           (reset),
      .cfg             (cfg),
      .cmd             (cmd),
      .sts             (sts),
      .in_first        (req_tuser),
      .in_start_x      (req_tdata[7:0]),
      .in_start_y      (req_tdata[15:8]),
      .in_char_code    (req_tdata[23:16]),
      .out_valid       (rsp_tvalid),
      .out_ready       (rsp_tready),
      .out_map_address (map_address),
      .out_tile_word   (tile_word),
      .out_last        (rsp_tlast)
   );

   assign rsp_tdata = {tile_word, map_address};

`ifndef NO_ASSERTIONS
   a_step_has_room: assert property (@(posedge clock) disable iff (reset)
      cmd.step |-> sts.out_free)
      else $error("word loaded while output register busy");

   a_last_frees_input: assert property (@(posedge clock) disable iff (reset)
      (cmd.step && sts.last_pos) |=> req_tready)
      else $error("input not ready after final word");

   a_advance_busy: assert property (@(posedge clock) disable iff (reset)
      cmd.advance |-> !req_tready)
      else $error("cursor advance while accepting input");

   a_one_phase: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.load, cmd.mul, cmd.base, cmd.step}))
      else $error("more than one datapath phase at once");
`endif

endmodule
`default_nettype wire
